// ===== rtl/tgc_pkg.sv =====
package tgc_pkg;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned SQ_W    = 2 * COORD_W;
  localparam int unsigned MOVE_W  = SQ_W + 1;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned FC_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned PANEL_WIDTH  = 480;
  localparam int unsigned PANEL_HEIGHT = 480;

  localparam logic [TIME_W-1:0]  HOLD_MS_RST        = 32'd1000;
  localparam logic [TIME_W-1:0]  LONG_HOLD_MS_RST   = 32'd10000;
  localparam logic [TIME_W-1:0]  RELEASE_MS_RST     = 32'd30;
  localparam logic [COORD_W-1:0] TAP_RADIUS_PX_RST  = 12'd20;
  localparam logic [COORD_W-1:0] SWIPE_MIN_PX_RST   = 12'd40;
  localparam logic [TIME_W-1:0]  TAP_CONFIRM_MS_RST = 32'd150;
  localparam logic [TIME_W-1:0]  REPRESS_MIN_MS_RST = 32'd60;

  localparam logic [FC_W-1:0] ONE_FINGER = 8'd1;

  typedef enum logic [2:0] {
    G_NONE  = 3'd0,
    G_UP    = 3'd1,
    G_DOWN  = 3'd2,
    G_LEFT  = 3'd3,
    G_RIGHT = 3'd4,
    G_TAP   = 3'd5,
    G_HOLD  = 3'd6
  } gesture_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLD_MS        = 3'd0,
    CFG_LONG_HOLD_MS   = 3'd1,
    CFG_RELEASE_MS     = 3'd2,
    CFG_TAP_RADIUS_PX  = 3'd3,
    CFG_SWIPE_MIN_PX   = 3'd4,
    CFG_TAP_CONFIRM_MS = 3'd5,
    CFG_REPRESS_MIN_MS = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  // outcome of finalizing a press
  typedef struct packed {
    logic              ev_gesture;
    logic              ev_tap;
    logic              ev_hold;
    gesture_e          code;
    logic [TIME_W-1:0] duration;
  } fin_t;

  function automatic logic [COORD_W-1:0] abs_diff(logic [COORD_W-1:0] a,
                                                  logic [COORD_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [MOVE_W-1:0] dist_sq(point_t a, point_t b);
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [SQ_W-1:0]    sx;
    logic [SQ_W-1:0]    sy;
    ax = abs_diff(a.x, b.x);
    ay = abs_diff(a.y, b.y);
    sx = SQ_W'(ax) * SQ_W'(ax);
    sy = SQ_W'(ay) * SQ_W'(ay);
    return {1'b0, sx} + {1'b0, sy};
  endfunction

endpackage

// ===== rtl/tgc_classify.sv =====
module tgc_classify (
  input  tgc_pkg::point_t                press_pt_i,
  input  tgc_pkg::point_t                rel_pt_i,
  input  logic [tgc_pkg::TIME_W-1:0]     press_stamp_i,
  input  logic [tgc_pkg::TIME_W-1:0]     rel_stamp_i,
  input  logic                           swipe_i,
  input  logic                           hold_i,
  input  logic                           tap_ok_i,
  input  logic [tgc_pkg::SQ_W-1:0]       rad_sq_i,
  input  logic [tgc_pkg::SQ_W-1:0]       swipe_sq_i,
  input  logic [tgc_pkg::TIME_W-1:0]     tap_confirm_ms_i,
  output tgc_pkg::fin_t                  fin_o
);

  logic [tgc_pkg::MOVE_W-1:0]  d2;
  logic [tgc_pkg::COORD_W-1:0] ax;
  logic [tgc_pkg::COORD_W-1:0] ay;
  logic [tgc_pkg::TIME_W-1:0]  dur;
  logic                        quick;
  tgc_pkg::gesture_e           code;

  always_comb begin
    d2    = tgc_pkg::dist_sq(rel_pt_i, press_pt_i);
    ax    = tgc_pkg::abs_diff(rel_pt_i.x, press_pt_i.x);
    ay    = tgc_pkg::abs_diff(rel_pt_i.y, press_pt_i.y);
    dur   = rel_stamp_i - press_stamp_i;
    quick = (dur != '0) && (dur < tap_confirm_ms_i);
    code  = tgc_pkg::G_NONE;
    if (swipe_i || (d2 >= {1'b0, swipe_sq_i})) begin
      // dominant axis picks the direction, ties go horizontal
      if (ax >= ay) begin
        code = (rel_pt_i.x >= press_pt_i.x) ? tgc_pkg::G_RIGHT : tgc_pkg::G_LEFT;
      end else begin
        code = (rel_pt_i.y >= press_pt_i.y) ? tgc_pkg::G_DOWN : tgc_pkg::G_UP;
      end
    end else if (hold_i) begin
      code = tgc_pkg::G_HOLD;
    end else if ((d2 <= {1'b0, rad_sq_i}) && (tap_ok_i || quick)) begin
      code = tgc_pkg::G_TAP;
    end
    fin_o.code       = code;
    fin_o.duration   = dur;
    fin_o.ev_gesture = (code != tgc_pkg::G_NONE);
    fin_o.ev_tap     = (code == tgc_pkg::G_TAP);
    fin_o.ev_hold    = (code == tgc_pkg::G_HOLD);
  end

endmodule

// ===== rtl/touch_gesture_classifier.sv =====
// touch gesture classifier
// input channel: one transfer per controller poll (finger count, raw x/y,
// millisecond timestamp). only a finger count of exactly one is a touch; x
// and y are clamped to the panel size before use.
// output channel: one result per poll with press/tap/hold/gesture events,
// the gesture code, press/hold/long-hold levels, the last touch point and
// the duration of the last finalized press, cleared when a new press starts.
// the transfer loads the input register, and the poll then moves through the
// classify logic into the state and result registers. throughput is one poll
// per cycle while the receiver takes results, limited only by the single pass
// through the distance squarers and compares.
// configuration writes take effect from the cycle after the write; threshold
// radii are squared at write time. write only while the block is idle.
// reset clears all tracking state, loads the default thresholds and empties
// both stages. when the receiver stalls, the result register holds and the
// input register keeps one more poll, after which in_ready_o drops.
module touch_gesture_classifier #(
  parameter int unsigned PanelWidth  = tgc_pkg::PANEL_WIDTH,
  parameter int unsigned PanelHeight = tgc_pkg::PANEL_HEIGHT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tgc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tgc_pkg::TIME_W-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [tgc_pkg::FC_W-1:0]         finger_count_i,
  input  logic [tgc_pkg::COORD_W-1:0]      x_raw_i,
  input  logic [tgc_pkg::COORD_W-1:0]      y_raw_i,
  input  logic [tgc_pkg::TIME_W-1:0]       now_ms_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             new_press_o,
  output logic                             new_tap_release_o,
  output logic                             new_hold_release_o,
  output logic                             new_gesture_o,
  output logic [2:0]                       gesture_code_o,
  output logic                             is_pressed_o,
  output logic                             is_hold_o,
  output logic                             is_long_hold_o,
  output logic [tgc_pkg::COORD_W-1:0]      cur_x_o,
  output logic [tgc_pkg::COORD_W-1:0]      cur_y_o,
  output logic [tgc_pkg::TIME_W-1:0]       press_duration_ms_o
);

  localparam int unsigned CW = tgc_pkg::COORD_W;
  localparam int unsigned TW = tgc_pkg::TIME_W;
  localparam logic [CW:0] XLimit = (CW + 1)'(PanelWidth);
  localparam logic [CW:0] YLimit = (CW + 1)'(PanelHeight);
  localparam logic [CW:0] XMax   = (CW + 1)'(PanelWidth - 1);
  localparam logic [CW:0] YMax   = (CW + 1)'(PanelHeight - 1);

  // configuration
  logic [TW-1:0]           hold_ms_q, long_hold_ms_q, release_ms_q;
  logic [TW-1:0]           tap_confirm_ms_q, repress_min_ms_q;
  logic [tgc_pkg::SQ_W-1:0] rad_sq_q, swipe_sq_q;
  logic [CW-1:0]           cfg_px;

  assign cfg_px = cfg_data_i[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ms_q        <= tgc_pkg::HOLD_MS_RST;
      long_hold_ms_q   <= tgc_pkg::LONG_HOLD_MS_RST;
      release_ms_q     <= tgc_pkg::RELEASE_MS_RST;
      rad_sq_q         <= tgc_pkg::SQ_W'(tgc_pkg::TAP_RADIUS_PX_RST)
                          * tgc_pkg::SQ_W'(tgc_pkg::TAP_RADIUS_PX_RST);
      swipe_sq_q       <= tgc_pkg::SQ_W'(tgc_pkg::SWIPE_MIN_PX_RST)
                          * tgc_pkg::SQ_W'(tgc_pkg::SWIPE_MIN_PX_RST);
      tap_confirm_ms_q <= tgc_pkg::TAP_CONFIRM_MS_RST;
      repress_min_ms_q <= tgc_pkg::REPRESS_MIN_MS_RST;
    end else if (cfg_we_i) begin
      case (tgc_pkg::cfg_idx_e'(cfg_idx_i))
        tgc_pkg::CFG_HOLD_MS:        hold_ms_q        <= cfg_data_i;
        tgc_pkg::CFG_LONG_HOLD_MS:   long_hold_ms_q   <= cfg_data_i;
        tgc_pkg::CFG_RELEASE_MS:     release_ms_q     <= cfg_data_i;
        tgc_pkg::CFG_TAP_RADIUS_PX:  rad_sq_q   <= tgc_pkg::SQ_W'(cfg_px) * tgc_pkg::SQ_W'(cfg_px);
        tgc_pkg::CFG_SWIPE_MIN_PX:   swipe_sq_q <= tgc_pkg::SQ_W'(cfg_px) * tgc_pkg::SQ_W'(cfg_px);
        tgc_pkg::CFG_TAP_CONFIRM_MS: tap_confirm_ms_q <= cfg_data_i;
        tgc_pkg::CFG_REPRESS_MIN_MS: repress_min_ms_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic            s1_valid_q;
  logic            s1_touch_q;
  tgc_pkg::point_t s1_pt_q;
  logic [TW-1:0]   s1_now_q;
  logic            s1_adv;
  logic            out_valid_q;
  tgc_pkg::point_t in_pt;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_comb begin
    in_pt.x = ({1'b0, x_raw_i} >= XLimit) ? XMax[CW-1:0] : x_raw_i;
    in_pt.y = ({1'b0, y_raw_i} >= YLimit) ? YMax[CW-1:0] : y_raw_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_touch_q <= (finger_count_i == tgc_pkg::ONE_FINGER);
      s1_pt_q    <= in_pt;
      s1_now_q   <= now_ms_i;
    end
  end

  // tracking state
  logic pressed_q, hold_q, long_q, tap_ok_q, swipe_q, rpend_q;
  logic pressed_d, hold_d, long_d, tap_ok_d, swipe_d, rpend_d;
  logic [tgc_pkg::MOVE_W-1:0] max_move_q, max_move_d;
  logic [TW-1:0]   press_stamp_q, press_stamp_d, rel_stamp_q, rel_stamp_d;
  tgc_pkg::point_t press_pt_q, press_pt_d, rel_pt_q, rel_pt_d, last_pt_q, last_pt_d;
  tgc_pkg::gesture_e gest_q, gest_d;
  logic [TW-1:0]   dur_q, dur_d;
  logic ev_press_q, ev_tap_q, ev_hold_q, ev_gest_q;
  logic ev_press_d, ev_tap_d, ev_hold_d, ev_gest_d;

  tgc_pkg::fin_t              fin;
  logic [TW-1:0]              gap, elapsed;
  logic [tgc_pkg::MOVE_W-1:0] d2;
  logic                       fin_touch, fin_rel, still_pressed, tap_set;

  tgc_classify u_classify (
    .press_pt_i       (press_pt_q),
    .rel_pt_i         (rel_pt_q),
    .press_stamp_i    (press_stamp_q),
    .rel_stamp_i      (rel_stamp_q),
    .swipe_i          (swipe_q),
    .hold_i           (hold_q),
    .tap_ok_i         (tap_ok_q),
    .rad_sq_i         (rad_sq_q),
    .swipe_sq_i       (swipe_sq_q),
    .tap_confirm_ms_i (tap_confirm_ms_q),
    .fin_o            (fin)
  );

  always_comb begin
    gap       = s1_now_q - rel_stamp_q;
    elapsed   = s1_now_q - press_stamp_q;
    d2        = tgc_pkg::dist_sq(s1_pt_q, press_pt_q);
    fin_touch = s1_touch_q && pressed_q && rpend_q && (gap >= repress_min_ms_q);
    fin_rel   = !s1_touch_q && pressed_q && rpend_q && (gap > release_ms_q);
    still_pressed = pressed_q && !fin_touch;
    tap_set   = 1'b0;

    pressed_d     = pressed_q;
    hold_d        = hold_q;
    long_d        = long_q;
    tap_ok_d      = tap_ok_q;
    swipe_d       = swipe_q;
    rpend_d       = rpend_q;
    max_move_d    = max_move_q;
    press_stamp_d = press_stamp_q;
    rel_stamp_d   = rel_stamp_q;
    press_pt_d    = press_pt_q;
    rel_pt_d      = rel_pt_q;
    last_pt_d     = last_pt_q;
    gest_d        = gest_q;
    dur_d         = dur_q;
    ev_press_d    = 1'b0;
    ev_tap_d      = 1'b0;
    ev_hold_d     = 1'b0;
    ev_gest_d     = 1'b0;

    // finalize the earlier press; a touch path then starts a new one
    if (fin_touch || fin_rel) begin
      ev_tap_d  = fin.ev_tap;
      ev_hold_d = fin.ev_hold;
      ev_gest_d = fin.ev_gesture;
      dur_d     = fin.duration;
      if (fin.ev_gesture) begin
        gest_d = fin.code;
      end
      pressed_d = 1'b0;
      hold_d    = 1'b0;
      long_d    = 1'b0;
      rpend_d   = 1'b0;
    end

    if (s1_touch_q) begin
      rpend_d   = 1'b0;
      last_pt_d = s1_pt_q;
      rel_pt_d  = s1_pt_q;
      if (!still_pressed) begin
        pressed_d     = 1'b1;
        press_stamp_d = s1_now_q;
        dur_d         = '0;
        press_pt_d    = s1_pt_q;
        gest_d        = tgc_pkg::G_NONE;
        tap_ok_d      = 1'b0;
        swipe_d       = 1'b0;
        max_move_d    = '0;
        ev_press_d    = 1'b1;
      end else begin
        max_move_d = (d2 > max_move_q) ? d2 : max_move_q;
        swipe_d    = swipe_q || (d2 >= {1'b0, swipe_sq_q});
        tap_set    = (elapsed >= tap_confirm_ms_q) && (max_move_d <= {1'b0, rad_sq_q});
        tap_ok_d   = (tap_ok_q || tap_set) && !swipe_d;
        if (!hold_q && (elapsed > hold_ms_q)) begin
          hold_d = 1'b1;
          if (!long_q && (elapsed > long_hold_ms_q)) begin
            long_d = 1'b1;
          end
        end
      end
    end else if (pressed_q && !rpend_q) begin
      rpend_d     = 1'b1;
      rel_stamp_d = s1_now_q;
      rel_pt_d    = last_pt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q     <= 1'b0;
      hold_q        <= 1'b0;
      long_q        <= 1'b0;
      tap_ok_q      <= 1'b0;
      swipe_q       <= 1'b0;
      rpend_q       <= 1'b0;
      max_move_q    <= '0;
      press_stamp_q <= '0;
      rel_stamp_q   <= '0;
      press_pt_q    <= '0;
      rel_pt_q      <= '0;
      last_pt_q     <= '0;
      gest_q        <= tgc_pkg::G_NONE;
      dur_q         <= '0;
      ev_press_q    <= 1'b0;
      ev_tap_q      <= 1'b0;
      ev_hold_q     <= 1'b0;
      ev_gest_q     <= 1'b0;
    end else if (s1_adv) begin
      pressed_q     <= pressed_d;
      hold_q        <= hold_d;
      long_q        <= long_d;
      tap_ok_q      <= tap_ok_d;
      swipe_q       <= swipe_d;
      rpend_q       <= rpend_d;
      max_move_q    <= max_move_d;
      press_stamp_q <= press_stamp_d;
      rel_stamp_q   <= rel_stamp_d;
      press_pt_q    <= press_pt_d;
      rel_pt_q      <= rel_pt_d;
      last_pt_q     <= last_pt_d;
      gest_q        <= gest_d;
      dur_q         <= dur_d;
      ev_press_q    <= ev_press_d;
      ev_tap_q      <= ev_tap_d;
      ev_hold_q     <= ev_hold_d;
      ev_gest_q     <= ev_gest_d;
    end
  end

  // result register: state only moves when a result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign new_press_o         = ev_press_q;
  assign new_tap_release_o   = ev_tap_q;
  assign new_hold_release_o  = ev_hold_q;
  assign new_gesture_o       = ev_gest_q;
  assign gesture_code_o      = gest_q;
  assign is_pressed_o        = pressed_q;
  assign is_hold_o           = hold_q;
  assign is_long_hold_o      = long_q;
  assign cur_x_o             = last_pt_q.x;
  assign cur_y_o             = last_pt_q.y;
  assign press_duration_ms_o = dur_q;

endmodule
